// ===== rtl/vklf_pkg.sv =====
package vklf_pkg;
  localparam int MAX_LEN_DEF = 4096;
  localparam logic [11:0] MIN_SPAN_RST = 12'd39;
  localparam logic [7:0] MARGIN_RST = 8'd2;
  localparam logic CFG_MIN_SPAN = 1'b0;
  localparam logic CFG_MARGIN = 1'b1;

  typedef enum logic [3:0] {
    ST_LOAD,
    ST_CNT_RD,
    ST_CNT_CMP,
    ST_CNT_WR,
    ST_THR,
    ST_SCAN_RD,
    ST_SCAN_WAIT,
    ST_SCAN_CHK,
    ST_DONE
  } state_t;
endpackage

// ===== rtl/vigenere_key_length_finder.sv =====
// Bytes load one per cycle (start accepted whenever busy is low).
// The last byte starts the analysis: shift counting over two
// copies of the text memory (each compare is a read, then a compare), a
// threshold step, then a period scan of read, wait and check steps per count read.
// busy is high throughout; out_valid strobes once, cannot be stalled. rst_n (synchronous)
// clears control state and restores min_span 39, margin 2; memories are not cleared.
module vigenere_key_length_finder #(
  parameter int MAX_LEN = vklf_pkg::MAX_LEN_DEF,
  localparam int AW = $clog2(MAX_LEN),
  localparam int LW = AW + 1
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  output logic             busy,
  input  logic [7:0]       in_text_byte,
  input  logic             in_last_byte,
  input  logic             cfg_we,
  input  logic             cfg_index,
  input  logic [11:0]      cfg_data,
  output logic             out_valid,
  output logic [12:0]      out_key_length,
  output logic [11:0]      out_peak_count
);
  vklf_pkg::state_t state_r, state_nxt;
  logic [11:0] min_span_r;
  logic [7:0]  margin_r;
  logic [LW-1:0] len_r, len_nxt;
  logic [LW-1:0] s_r, s_nxt, i_r, i_nxt;
  logic [LW-1:0] p_r, p_nxt, m_r, m_nxt;
  logic [LW-1:0] cnt_r, cnt_nxt, peak_r, peak_nxt;
  logic [LW-1:0] span_r, span_nxt;
  logic signed [LW+1:0] thr_r, thr_nxt;
  logic [12:0] key_r, key_nxt;
  logic        out_valid_r, out_valid_nxt;

  logic          ta_we;
  logic [AW-1:0] ta_waddr, ta_raddr, tb_raddr, sc_raddr;
  logic [7:0]    ta_rdata, tb_rdata;
  logic          sc_we;
  logic [LW-1:0] sc_rdata;
  logic          accept;
  logic [LW-1:0] n8;
  logic [LW:0]   m_sum;
  logic [LW-1:0] cnt_eff;

  assign accept = start && !busy;

  vklf_ram #(.WIDTH(8), .DEPTH(MAX_LEN)) u_text_a (
    .clk(clk), .we(ta_we), .waddr(ta_waddr), .wdata(in_text_byte),
    .raddr(ta_raddr), .rdata(ta_rdata)
  );
  vklf_ram #(.WIDTH(8), .DEPTH(MAX_LEN)) u_text_b (
    .clk(clk), .we(ta_we), .waddr(ta_waddr), .wdata(in_text_byte),
    .raddr(tb_raddr), .rdata(tb_rdata)
  );
  vklf_ram #(.WIDTH(LW), .DEPTH(MAX_LEN)) u_counts (
    .clk(clk), .we(sc_we), .waddr(s_r[AW-1:0]), .wdata(cnt_r),
    .raddr(sc_raddr), .rdata(sc_rdata)
  );

  assign ta_we    = accept && (len_r < LW'(MAX_LEN));
  assign ta_waddr = len_r[AW-1:0];
  assign ta_raddr = i_r[AW-1:0];
  assign tb_raddr = LW'(i_r + s_r) >= LW'(MAX_LEN) ? '0 : AW'(i_r + s_r);
  assign sc_raddr = m_r[AW-1:0];
  assign sc_we    = (state_r == vklf_pkg::ST_CNT_WR);
  assign n8       = len_r >> 3;
  assign m_sum    = {1'b0, m_r} + {1'b0, p_r};
  assign cnt_eff  = (m_r >= len_r) ? '0 : sc_rdata;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= vklf_pkg::ST_LOAD;
      min_span_r  <= vklf_pkg::MIN_SPAN_RST;
      margin_r    <= vklf_pkg::MARGIN_RST;
      len_r       <= '0;
      peak_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      len_r       <= len_nxt;
      peak_r      <= peak_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we) begin
        case (cfg_index)
          vklf_pkg::CFG_MIN_SPAN: min_span_r <= cfg_data;
          vklf_pkg::CFG_MARGIN:   margin_r   <= cfg_data[7:0];
          default: ;
        endcase
      end
    end
    s_r    <= s_nxt;
    i_r    <= i_nxt;
    p_r    <= p_nxt;
    m_r    <= m_nxt;
    cnt_r  <= cnt_nxt;
    span_r <= span_nxt;
    thr_r  <= thr_nxt;
    key_r  <= key_nxt;
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      vklf_pkg::ST_LOAD:
        if (accept && in_last_byte) state_nxt = vklf_pkg::ST_CNT_RD;
      vklf_pkg::ST_CNT_RD:
        if (s_r >= len_r) state_nxt = vklf_pkg::ST_THR;
        else if (LW'(i_r + s_r) >= len_r) state_nxt = vklf_pkg::ST_CNT_WR;
        else state_nxt = vklf_pkg::ST_CNT_CMP;
      vklf_pkg::ST_CNT_CMP: state_nxt = vklf_pkg::ST_CNT_RD;
      vklf_pkg::ST_CNT_WR:  state_nxt = vklf_pkg::ST_CNT_RD;
      vklf_pkg::ST_THR:     state_nxt = vklf_pkg::ST_SCAN_RD;
      vklf_pkg::ST_SCAN_RD:
        if (p_r >= len_r) state_nxt = vklf_pkg::ST_DONE;
        else if (m_r >= span_r) begin
          if (m_r > span_r && {p_r, 1'b0} <= {1'b0, span_r}) state_nxt = vklf_pkg::ST_DONE;
          else state_nxt = vklf_pkg::ST_SCAN_RD;
        end else state_nxt = vklf_pkg::ST_SCAN_WAIT;
      vklf_pkg::ST_SCAN_WAIT: state_nxt = vklf_pkg::ST_SCAN_CHK;
      vklf_pkg::ST_SCAN_CHK:  state_nxt = vklf_pkg::ST_SCAN_RD;
      vklf_pkg::ST_DONE:      state_nxt = vklf_pkg::ST_LOAD;
      default:                state_nxt = vklf_pkg::ST_LOAD;
    endcase
  end

  always_comb begin
    len_nxt       = len_r;
    s_nxt         = s_r;
    i_nxt         = i_r;
    p_nxt         = p_r;
    m_nxt         = m_r;
    cnt_nxt       = cnt_r;
    peak_nxt      = peak_r;
    span_nxt      = span_r;
    thr_nxt       = thr_r;
    key_nxt       = key_r;
    out_valid_nxt = 1'b0;
    case (state_r)
      vklf_pkg::ST_LOAD: begin
        if (ta_we) len_nxt = LW'(len_r + 1'b1);
        if (accept && in_last_byte) begin
          s_nxt = LW'(1); i_nxt = '0; cnt_nxt = '0; peak_nxt = '0;
        end
      end
      vklf_pkg::ST_CNT_CMP: begin
        if (ta_rdata == tb_rdata) cnt_nxt = LW'(cnt_r + 1'b1);
        i_nxt = LW'(i_r + 1'b1);
      end
      vklf_pkg::ST_CNT_WR: begin
        if (cnt_r > peak_r) peak_nxt = cnt_r;
        s_nxt = LW'(s_r + 1'b1); i_nxt = '0; cnt_nxt = '0;
      end
      vklf_pkg::ST_THR: begin
        span_nxt = (n8 < LW'(min_span_r)) ? LW'(min_span_r) : n8;
        thr_nxt  = $signed({2'b00, peak_r >> 1}) - $signed({{(LW-6){1'b0}}, margin_r});
        p_nxt = LW'(1); m_nxt = LW'(1); key_nxt = '0;
      end
      vklf_pkg::ST_SCAN_RD: begin
        if (p_r < len_r && m_r >= span_r) begin
          if (m_r > span_r && {p_r, 1'b0} <= {1'b0, span_r}) key_nxt = 13'(p_r);
          else begin
            p_nxt = LW'(p_r + 1'b1); m_nxt = LW'(p_r + 1'b1);
          end
        end
      end
      vklf_pkg::ST_SCAN_CHK: begin
        if ($signed({2'b00, cnt_eff}) < thr_r) begin
          if (m_r > span_r && {p_r, 1'b0} <= {1'b0, span_r}) m_nxt = m_r;
          else begin
            p_nxt = LW'(p_r + 1'b1); m_nxt = LW'(p_r + 1'b1);
          end
        end else if (m_sum[LW]) begin
          m_nxt = '1;
        end else begin
          m_nxt = m_sum[LW-1:0];
        end
      end
      vklf_pkg::ST_DONE: begin
        out_valid_nxt = 1'b1;
        len_nxt = '0;
      end
      default: ;
    endcase
  end

  assign busy           = (state_r != vklf_pkg::ST_LOAD);
  assign out_valid      = out_valid_r;
  assign out_key_length = key_r;
  assign out_peak_count = peak_r[11:0];
endmodule

// ===== rtl/vklf_ram.sv =====
module vklf_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

// ===== test/vigenere_key_length_finder_tb.sv =====
`timescale 1ns / 1ps

module vigenere_key_length_finder_tb;

  localparam int STORE_DEPTH = 4096;
  localparam longint CYCLE_LIMIT = 40_000_000;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        start = 1'b0;
  logic        busy;
  logic [7:0]  in_text_byte = '0;
  logic        in_last_byte = 1'b0;
  logic        cfg_we = 1'b0;
  logic        cfg_index = vklf_pkg::CFG_MIN_SPAN;
  logic [11:0] cfg_data = '0;
  logic        out_valid;
  logic [12:0] out_key_length;
  logic [11:0] out_peak_count;

  logic [11:0] span_floor = vklf_pkg::MIN_SPAN_RST;
  logic [7:0]  peak_margin = vklf_pkg::MARGIN_RST;
  logic [7:0]  text_bytes[$];
  logic [12:0] exp_key_q[$];
  logic [11:0] exp_peak_q[$];
  int          error_count = 0;
  longint      cycle_count = 0;
  int          burst_left = 0;

  vigenere_key_length_finder dut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_text_byte(in_text_byte), .in_last_byte(in_last_byte),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .out_valid(out_valid), .out_key_length(out_key_length),
    .out_peak_count(out_peak_count)
  );

  always #6 clk = ~clk;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  task automatic report(input string msg);
    $display("mismatch @%0t: %s", $time, msg);
    error_count++;
  endtask

  // coincidence counts, peak and first qualifying period for the current text
  task automatic find_key_length(output logic [12:0] key, output logic [11:0] peak);
    int n, s, i, p, m, span, thr;
    int counts[STORE_DEPTH];
    n = text_bytes.size();
    peak = '0;
    key = '0;
    for (s = 1; s < n; s++) begin
      counts[s] = 0;
      for (i = 0; i + s < n; i++)
        if (text_bytes[i] == text_bytes[i + s]) counts[s]++;
      if (counts[s] > int'(peak)) peak = 12'(counts[s]);
    end
    span = n / 8;
    if (span < int'(span_floor)) span = int'(span_floor);
    thr = int'(peak / 2) - int'(peak_margin);
    for (p = 1; p < n; p++) begin
      m = p;
      while (m < span) begin
        if (((m < n) ? counts[m] : 0) < thr) break;
        m += p;
      end
      if (m > span && 2 * p <= span) begin
        key = 13'(p);
        break;
      end
    end
  endtask

  always @(posedge clk) begin
    if (out_valid) begin
      if (exp_key_q.size() == 0) begin
        report("result with no request pending");
      end else begin
        if (out_key_length !== exp_key_q[0])
          report($sformatf("key_length %0d, expected %0d", out_key_length, exp_key_q[0]));
        if (out_peak_count !== exp_peak_q[0])
          report($sformatf("peak_count %0d, expected %0d", out_peak_count, exp_peak_q[0]));
        void'(exp_key_q.pop_front());
        void'(exp_peak_q.pop_front());
      end
    end
  end

  task automatic idle_cycles(input int n);
    start <= 1'b0;
    repeat (n) @(posedge clk);
  endtask

  task automatic send_byte(input logic [7:0] b, input logic last);
    logic [12:0] k;
    logic [11:0] pk;
    if (burst_left == 0) begin
      if ($urandom_range(0, 2) == 0) idle_cycles($urandom_range(1, 6));
      burst_left = $urandom_range(1, 20);
    end
    burst_left--;
    start <= 1'b1;
    in_text_byte <= b;
    in_last_byte <= last;
    do @(posedge clk); while (busy);
    if (text_bytes.size() < STORE_DEPTH) text_bytes.push_back(b);
    if (last) begin
      find_key_length(k, pk);
      exp_key_q.push_back(k);
      exp_peak_q.push_back(pk);
      text_bytes.delete();
    end
  endtask

  task automatic drain();
    idle_cycles(1);
    while (exp_key_q.size() != 0 || busy) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_cfg(input logic idx, input logic [11:0] val);
    drain();
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == vklf_pkg::CFG_MIN_SPAN) span_floor = val;
    else peak_margin = val[7:0];
  endtask

  // ciphertext: small-alphabet plaintext plus a repeating key, or plain noise
  task automatic send_text(input int n, input int key_len, input bit noise);
    logic [7:0] key_bytes[16];
    logic [7:0] b;
    int i;
    for (i = 0; i < 16; i++) key_bytes[i] = 8'($urandom);
    for (i = 0; i < n; i++) begin
      if (noise) b = 8'($urandom);
      else b = 8'($urandom_range(0, 3)) + key_bytes[i % key_len];
      send_byte(b, i == n - 1);
    end
  endtask

  task automatic test_edge_bytes();
    send_byte(8'h00, 1'b1);
    send_byte(8'hff, 1'b1);
    send_byte(8'h00, 1'b0);
    send_byte(8'h00, 1'b0);
    send_byte(8'hff, 1'b0);
    send_byte(8'h00, 1'b1);
    send_text(24, 3, 1'b0);
  endtask

  task automatic test_config_extremes();
    write_cfg(vklf_pkg::CFG_MIN_SPAN, 12'd1);
    write_cfg(vklf_pkg::CFG_MARGIN, 12'd0);
    send_text(12, 2, 1'b0);
    write_cfg(vklf_pkg::CFG_MIN_SPAN, 12'd4095);
    write_cfg(vklf_pkg::CFG_MARGIN, 12'hfff);
    send_text(10, 1, 1'b0);
    write_cfg(vklf_pkg::CFG_MIN_SPAN, 12'd8);
    write_cfg(vklf_pkg::CFG_MARGIN, 12'h0a5);
    send_text(20, 4, 1'b0);
  endtask

  task automatic test_random();
    int sent, n, r;
    sent = 0;
    while (sent < 500) begin
      if ($urandom_range(0, 3) == 0) begin
        r = $urandom_range(0, 5);
        case (r)
          0: write_cfg(vklf_pkg::CFG_MIN_SPAN, 12'd1);
          1: write_cfg(vklf_pkg::CFG_MIN_SPAN, 12'd4095);
          default: write_cfg(vklf_pkg::CFG_MIN_SPAN, 12'($urandom_range(1, 40)));
        endcase
        r = $urandom_range(0, 4);
        case (r)
          0: write_cfg(vklf_pkg::CFG_MARGIN, 12'd0);
          1: write_cfg(vklf_pkg::CFG_MARGIN, 12'd255);
          default: write_cfg(vklf_pkg::CFG_MARGIN, 12'($urandom));
        endcase
      end
      r = $urandom_range(0, 19);
      if (r == 0) n = 1;
      else if (r == 1) n = $urandom_range(100, 200);
      else n = $urandom_range(2, 16);
      send_text(n, $urandom_range(1, 8), $urandom_range(0, 4) == 0);
      sent += n;
    end
  endtask

  initial begin
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_edge_bytes();
    test_config_extremes();
    test_random();
    drain();
    repeat (20) @(posedge clk);
    if (error_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end
endmodule

// ===== vigenere_key_length_finder.f =====
rtl/vklf_pkg.sv
rtl/vklf_ram.sv
rtl/vigenere_key_length_finder.sv
test/vigenere_key_length_finder_tb.sv
